FILE: sv/frpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frpm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;
   localparam int SQUARE_W   = 32;
   localparam int RADICAND_W = 32;
   localparam int ROOT_STEPS = RADICAND_W / 2;
   localparam int ROOT_REM_W = LEVEL_W + 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in_frame;
      logic                       clear_max;
   } frpm_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] frame_rms;
      logic [LEVEL_W-1:0] frame_peak;
      logic [LEVEL_W-1:0] max_rms;
      logic [LEVEL_W-1:0] max_peak;
   } frpm_rsp_type;

endpackage

`default_nettype wire

FILE: sv/frame_rms_peak_meter.sv
`timescale 1ns / 1ps
`default_nettype none

// Audio level meter. Push signed 16-bit samples; each is squared and summed
// and its magnitude (-32768 reads as 32768) feeds the frame peak. A frame
// closes on a sample with last_in_frame set or on the sample that reaches
// MAX_FRAME_SAMPLES; it then yields one transaction on the rsp side with the
// frame RMS (floor square root of floor(sum / count)), the frame peak, and
// the running maxima of both. clear_max on any sample of a frame zeroes the
// maxima before that frame's result folds in. Samples that do not close a
// frame produce no transaction. The accumulator takes one sample per
// cycle while req_full is low. Each closed frame then passes through the
// back end in order: a load step, one-bit-per-cycle restoring division,
// digit-by-digit square root, and a write of the result register. A
// two-entry frame queue sits between the accumulator and the back end;
// req_full rises only while that queue holds two closed frames, so short
// frames back-to-back throttle to the back-end rate while long frames
// stream at one sample per cycle.

module frame_rms_peak_meter #(
   parameter int MAX_FRAME_SAMPLES = 1024
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_push,
   output logic                    req_full,
   input  frpm_pkg::frpm_req_type  req_data,
   output logic                    rsp_empty,
   input  wire                     rsp_pop,
   output frpm_pkg::frpm_rsp_type  rsp_data
);
   import frpm_pkg::*;

   // count must hold the limit itself; sum grows by 2^30 per sample
   localparam int CNT_W       = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W       = SQUARE_W - 2 + CNT_W;
   localparam int REC_W       = SUM_W + CNT_W + LEVEL_W + 1;
   localparam int QUEUE_DEPTH = 2;

   logic                 accept;
   logic                 f_push;
   logic [SUM_W-1:0]     f_sum;
   logic [CNT_W-1:0]     f_count;
   logic [LEVEL_W-1:0]   f_peak;
   logic                 f_clear;
   logic                 q_full, q_empty, q_pop;
   logic [REC_W-1:0]     q_wdata, q_rdata;
   logic [SUM_W-1:0]     b_sum;
   logic [CNT_W-1:0]     b_count;
   logic [LEVEL_W-1:0]   b_peak;
   logic                 b_clear;

   // hold every sample off while the frame queue is full
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: accumulate squares, count, peak and the pending clear
   frpm_front #(
      .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
      .CNT_W            (CNT_W),
      .SUM_W            (SUM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .rec_push (f_push),
      .rec_sum  (f_sum),
      .rec_count(f_count),
      .rec_peak (f_peak),
      .rec_clear(f_clear)
   );

   // pack one closed frame per queue entry
   assign q_wdata = {f_sum, f_count, f_peak, f_clear};
   assign {b_sum, b_count, b_peak, b_clear} = q_rdata;

   frpm_fifo #(
      .DATA_W(REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_data(q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .empty    (q_empty)
   );

   // back: divide, square root, fold into maxima, drive the result register
   frpm_back #(
      .CNT_W(CNT_W),
      .SUM_W(SUM_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .rec_valid(!q_empty),
      .rec_pop  (q_pop),
      .rec_sum  (b_sum),
      .rec_count(b_count),
      .rec_peak (b_peak),
      .rec_clear(b_clear),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

FILE: sv/frpm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module frpm_front #(
   parameter int MAX_FRAME_SAMPLES = 1024,
   parameter int CNT_W             = 11,
   parameter int SUM_W             = 41
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           accept,
   input  frpm_pkg::frpm_req_type        req,
   output logic                          rec_push,
   output logic [SUM_W-1:0]              rec_sum,
   output logic [CNT_W-1:0]              rec_count,
   output logic [frpm_pkg::LEVEL_W-1:0]  rec_peak,
   output logic                          rec_clear
);
   import frpm_pkg::*;

   logic [SUM_W-1:0]   sum_ff,   sum_in;
   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [LEVEL_W-1:0] peak_ff,  peak_in;
   logic               clr_ff,   clr_in;

   logic [LEVEL_W-1:0]  mag;
   logic [SQUARE_W-1:0] square;
   logic [SUM_W-1:0]    sum_next;
   logic [CNT_W-1:0]    cnt_next;
   logic [LEVEL_W-1:0]  peak_next;
   logic                clr_next;
   logic                close;

   always_comb begin
      // two's complement negate keeps -32768 as 32768 in an unsigned view
      mag       = req.sample[SAMPLE_W-1] ? LEVEL_W'(-req.sample) : LEVEL_W'(req.sample);
      square    = SQUARE_W'(mag) * SQUARE_W'(mag);
      sum_next  = sum_ff + SUM_W'(square);
      cnt_next  = cnt_ff + CNT_W'(1);
      peak_next = (mag > peak_ff) ? mag : peak_ff;
      clr_next  = clr_ff | req.clear_max;
      close     = req.last_in_frame || (cnt_next == CNT_W'(MAX_FRAME_SAMPLES));

      rec_push  = accept && close;
      rec_sum   = sum_next;
      rec_count = cnt_next;
      rec_peak  = peak_next;
      rec_clear = clr_next;

      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      peak_in = peak_ff;
      clr_in  = clr_ff;
      if (accept) begin
         if (close) begin
            sum_in  = '0;
            cnt_in  = '0;
            peak_in = '0;
            clr_in  = 1'b0;
         end else begin
            sum_in  = sum_next;
            cnt_in  = cnt_next;
            peak_in = peak_next;
            clr_in  = clr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         peak_ff <= '0;
         clr_ff  <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         peak_ff <= peak_in;
         clr_ff  <= clr_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/frpm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module frpm_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [DATA_W-1:0] push_data,
   output logic              full,
   input  wire               pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff,    cnt_in;
   logic              do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
      ptr_advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      full     = (cnt_ff == CNT_W'(DEPTH));
      empty    = (cnt_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem[rd_ptr_ff];

      wr_ptr_in = do_push ? ptr_advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_advance(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/frpm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module frpm_back #(
   parameter int CNT_W = 11,
   parameter int SUM_W = 41
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           rec_valid,
   output logic                          rec_pop,
   input  wire  [SUM_W-1:0]              rec_sum,
   input  wire  [CNT_W-1:0]              rec_count,
   input  wire  [frpm_pkg::LEVEL_W-1:0]  rec_peak,
   input  wire                           rec_clear,
   output logic                          rsp_empty,
   input  wire                           rsp_pop,
   output frpm_pkg::frpm_rsp_type        rsp_data
);
   import frpm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]            state_ff,   state_in;
   logic [STEP_W-1:0]     step_ff,    step_in;
   logic [SUM_W-1:0]      quo_ff,     quo_in;
   logic [CNT_W-1:0]      drem_ff,    drem_in;
   logic [CNT_W-1:0]      divisor_ff, divisor_in;
   logic [RADICAND_W-1:0] rad_ff,     rad_in;
   logic [ROOT_REM_W-3:0] rrem_ff,    rrem_in;
   logic [LEVEL_W-1:0]    root_ff,    root_in;
   logic [LEVEL_W-1:0]    peak_ff,    peak_in;
   logic                  clr_ff,     clr_in;
   logic [LEVEL_W-1:0]    max_rms_ff, max_rms_in;
   logic [LEVEL_W-1:0]    max_pk_ff,  max_pk_in;
   logic                  out_vld_ff, out_vld_in;
   frpm_rsp_type          out_ff,     out_in;

   logic [CNT_W:0]        dtrial;
   logic                  dbit;
   logic [SUM_W-1:0]      quo_step;
   logic [SUM_W+RADICAND_W-1:0] quo_wide;
   logic [ROOT_REM_W-1:0] rtrial, rsub;
   logic                  rbit;
   logic [LEVEL_W-1:0]    base_rms, base_pk;
   logic                  slot_free;

   always_comb begin
      // one restoring-division bit per cycle
      dtrial   = {drem_ff, quo_ff[SUM_W-1]};
      dbit     = (dtrial >= {1'b0, divisor_ff});
      quo_step = {quo_ff[SUM_W-2:0], dbit};
      quo_wide = {{RADICAND_W{1'b0}}, quo_step};

      // one root digit per cycle, two radicand bits consumed
      rtrial = {rrem_ff, rad_ff[RADICAND_W-1 -: 2]};
      rsub   = {2'b00, root_ff, 2'b01};
      rbit   = (rtrial >= rsub);

      base_rms  = clr_ff ? '0 : max_rms_ff;
      base_pk   = clr_ff ? '0 : max_pk_ff;
      slot_free = !out_vld_ff || rsp_pop;

      rsp_empty = !out_vld_ff;
      rsp_data  = out_ff;
      rec_pop   = (state_ff == ST_IDLE) && rec_valid;

      state_in   = state_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      drem_in    = drem_ff;
      divisor_in = divisor_ff;
      rad_in     = rad_ff;
      rrem_in    = rrem_ff;
      root_in    = root_ff;
      peak_in    = peak_ff;
      clr_in     = clr_ff;
      max_rms_in = max_rms_ff;
      max_pk_in  = max_pk_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_pop;

      case (state_ff)
         ST_IDLE: begin
            if (rec_valid) begin
               quo_in     = rec_sum;
               drem_in    = '0;
               divisor_in = rec_count;
               peak_in    = rec_peak;
               clr_in     = rec_clear;
               step_in    = STEP_W'(SUM_W - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in  = quo_step;
            drem_in = dbit ? CNT_W'(dtrial - {1'b0, divisor_ff}) : CNT_W'(dtrial);
            if (step_ff == '0) begin
               // mean square fits the radicand, drop the empty high bits
               rad_in   = quo_wide[RADICAND_W-1:0];
               rrem_in  = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_STEPS - 1);
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[RADICAND_W-3:0], 2'b00};
            rrem_in = rbit ? (ROOT_REM_W-2)'(rtrial - rsub) : (ROOT_REM_W-2)'(rtrial);
            root_in = {root_ff[LEVEL_W-2:0], rbit};
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               max_rms_in        = (root_ff > base_rms) ? root_ff : base_rms;
               max_pk_in         = (peak_ff > base_pk) ? peak_ff : base_pk;
               out_in.frame_rms  = root_ff;
               out_in.frame_peak = peak_ff;
               out_in.max_rms    = max_rms_in;
               out_in.max_peak   = max_pk_in;
               out_vld_in        = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         max_rms_ff <= '0;
         max_pk_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         max_rms_ff <= max_rms_in;
         max_pk_ff  <= max_pk_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      drem_ff    <= drem_in;
      divisor_ff <= divisor_in;
      rad_ff     <= rad_in;
      rrem_ff    <= rrem_in;
      root_ff    <= root_in;
      peak_ff    <= peak_in;
      clr_ff     <= clr_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire
